>>> src/lmqs_pkg.sv
// lmqs_pkg: shared constants, types and address helpers for the quarter-scan driver
// depends on: nothing
// used by: lmqs_front, lmqs_back, lmqs_out_q, led_matrix_quarter_scan_driver_top
package lmqs_pkg;

    // panel geometry
    localparam int BYTES_PER_ROW  = 8;
    localparam int PANELS_CHAINED = 2;
    localparam int ROWS_PER_BANK  = 16;
    localparam int BANK_BYTES     = 128;

    localparam int NUM_BANKS      = 8;
    localparam int NUM_QUARTERS   = 4;
    localparam int NUM_SCAN_ROWS  = 4;
    localparam int QUARTER_STRIDE = 16 * PANELS_CHAINED;
    localparam int GROUPS         = NUM_QUARTERS * BYTES_PER_ROW;

    // widths
    localparam int ADDR_W  = $clog2(BANK_BYTES);
    localparam int BANK_W  = $clog2(NUM_BANKS);
    localparam int QTR_W   = $clog2(NUM_QUARTERS);
    localparam int GRP_W   = $clog2(GROUPS);
    localparam int ROW_W   = $clog2(NUM_SCAN_ROWS);
    localparam int CALC_W  = 12;
    localparam int LANES_W = 8 * NUM_BANKS;

    // classified request as it sits in the queue between front and back
    typedef struct packed {
        logic              is_tick;
        logic              in_range;
        logic [ADDR_W-1:0] row;
        logic [BANK_W-1:0] lane;
        logic [7:0]        mask;
        logic              on;
    } op_t;

    // one result group
    typedef struct packed {
        logic [LANES_W-1:0] lanes;
        logic [ROW_W-1:0]   row_sel;
        logic               last;
    } out_item_t;

    // back-end sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_WRITE,
        S_SCAN
    } back_state_t;

    // frame store address of one group of a scan tick
    function automatic logic [CALC_W-1:0] scan_addr(
        input logic [GRP_W-1:0] grp,
        input logic [ROW_W-1:0] row
    );
        logic [CALC_W-1:0] q;
        logic [CALC_W-1:0] i;
        logic [CALC_W-1:0] r;
        q = CALC_W'(NUM_QUARTERS - 1) - CALC_W'(grp[QTR_W-1:0]);
        i = CALC_W'(grp >> QTR_W);
        r = CALC_W'(row);
        return q * CALC_W'(QUARTER_STRIDE) + i + r * CALC_W'(BYTES_PER_ROW);
    endfunction

endpackage

>>> src/lmqs_front.sv
// lmqs_front: accepts requests, decodes pixel addresses and holds them in a two-entry queue
// depends on: lmqs_pkg
module lmqs_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic          req_type,
    input  logic [5:0]    pixel_x,
    input  logic [6:0]    pixel_y,
    input  logic          pixel_on,
    output logic          op_valid,
    output lmqs_pkg::op_t op,
    input  logic          op_pop
);
    import lmqs_pkg::*;

    op_t               slot_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    op_t               dec;
    logic [CALC_W-1:0] bank;
    logic [CALC_W-1:0] line;
    logic [CALC_W-1:0] addr;
    logic              do_push;
    logic              do_pop;

    // decode pixel coordinates into row, lane and bit mask
    always_comb
    begin
        bank = CALC_W'(pixel_y) / CALC_W'(ROWS_PER_BANK);
        line = CALC_W'(pixel_y) % CALC_W'(ROWS_PER_BANK);
        addr = line * CALC_W'(BYTES_PER_ROW) + CALC_W'(pixel_x >> 3);
        dec.is_tick  = req_type;
        dec.in_range = (bank < CALC_W'(NUM_BANKS)) && (addr < CALC_W'(BANK_BYTES));
        dec.row      = addr[ADDR_W-1:0];
        dec.lane     = bank[BANK_W-1:0];
        dec.mask     = 8'h80 >> pixel_x[2:0];
        dec.on       = pixel_on;
    end

    // queue control
    always_comb
    begin
        full        = (count_reg == 2'd2);
        op_valid    = (count_reg != 2'd0);
        op          = slot_reg[rd_ptr_reg];
        do_push     = push && !full;
        do_pop      = op_pop && op_valid;
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

>>> src/lmqs_out_q.sv
// lmqs_out_q: two-entry result queue between the back end and the output ports
// depends on: lmqs_pkg
module lmqs_out_q (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_push,
    input  lmqs_pkg::out_item_t in_item,
    output logic                in_full,
    input  logic                pop,
    output logic                empty,
    output lmqs_pkg::out_item_t out_item
);
    import lmqs_pkg::*;

    out_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    // pointer and count update
    always_comb
    begin
        in_full     = (count_reg == 2'd2);
        empty       = (count_reg == 2'd0);
        out_item    = slot_reg[rd_ptr_reg];
        do_push     = in_push && !in_full;
        do_pop      = pop && !empty;
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> src/lmqs_back.sv
// lmqs_back: frame store, pixel read-modify-write and scan group sequencer
// depends on: lmqs_pkg
module lmqs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    input  lmqs_pkg::op_t       op,
    output logic                op_pop,
    output logic                out_push,
    output lmqs_pkg::out_item_t out_item,
    input  logic                out_full
);
    import lmqs_pkg::*;

    // frame store: one word per address, byte k holds bank k
    logic [LANES_W-1:0]    mem [BANK_BYTES];
    logic [BANK_BYTES-1:0] row_valid_reg;

    back_state_t        state_reg, state_next;
    logic [GRP_W-1:0]   grp_reg, grp_next;
    logic [ROW_W-1:0]   scan_row_reg, scan_row_next;
    logic [ADDR_W-1:0]  wrow_reg, wrow_next;
    logic [BANK_W-1:0]  lane_reg, lane_next;
    logic [7:0]         mask_reg, mask_next;
    logic               on_reg, on_next;

    logic               rd_en;
    logic [CALC_W-1:0]  rd_addr;
    logic [LANES_W-1:0] rd_data_reg;
    logic               rd_ok_reg;
    logic               rd_in_range;
    logic               we;
    logic [LANES_W-1:0] wdata;
    logic [LANES_W-1:0] old_word;
    logic [LANES_W-1:0] bit_mask;
    logic               last_grp;

    // read data, zero where never written or out of bank
    assign old_word    = rd_ok_reg ? rd_data_reg : '0;
    assign bit_mask    = LANES_W'(mask_reg) << (8 * lane_reg);
    assign wdata       = on_reg ? (old_word | bit_mask) : (old_word & ~bit_mask);
    assign last_grp    = (grp_reg == GRP_W'(GROUPS - 1));
    assign rd_in_range = (rd_addr < CALC_W'(BANK_BYTES));

    // sequencer next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        grp_next      = grp_reg;
        scan_row_next = scan_row_reg;
        wrow_next     = wrow_reg;
        lane_next     = lane_reg;
        mask_next     = mask_reg;
        on_next       = on_reg;
        op_pop        = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = CALC_W'(op.row);
        we            = 1'b0;
        out_push      = 1'b0;
        out_item.lanes   = ~old_word;
        out_item.row_sel = last_grp ? scan_row_reg : '0;
        out_item.last    = last_grp;
        unique case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    op_pop = 1'b1;
                    if (op.is_tick)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = scan_addr('0, scan_row_reg);
                        grp_next   = '0;
                        state_next = S_SCAN;
                    end
                    else if (op.in_range)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = CALC_W'(op.row);
                        wrow_next  = op.row;
                        lane_next  = op.lane;
                        mask_next  = op.mask;
                        on_next    = op.on;
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE:
            begin
                we         = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (!out_full)
                begin
                    out_push = 1'b1;
                    if (last_grp)
                    begin
                        scan_row_next = scan_row_reg + 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        grp_next = grp_reg + 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = scan_addr(grp_reg + 1'b1, scan_row_reg);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            grp_reg       <= '0;
            scan_row_reg  <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            grp_reg      <= grp_next;
            scan_row_reg <= scan_row_next;
            if (we)
            begin
                row_valid_reg[wrow_reg] <= 1'b1;
            end
        end
    end

    // pending write payload
    always_ff @(posedge clk)
    begin
        wrow_reg <= wrow_next;
        lane_reg <= lane_next;
        mask_reg <= mask_next;
        on_reg   <= on_next;
    end

    // frame store port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr[ADDR_W-1:0]];
            rd_ok_reg   <= rd_in_range && row_valid_reg[rd_addr[ADDR_W-1:0]];
        end
        if (we)
        begin
            mem[wrow_reg] <= wdata;
        end
    end

    // checks
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into a full queue");

    a_grp_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && out_push && !last_grp) |=>
            (grp_reg == $past(grp_reg) + 1'b1))
        else $error("scan group counter did not advance");

    a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && last_grp) |=>
            (scan_row_reg == $past(scan_row_reg) + 1'b1) && (state_reg == S_IDLE))
        else $error("scan row did not advance after latch group");

    a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |=> (state_reg == S_IDLE))
        else $error("pixel write did not complete in one cycle");

endmodule

>>> src/led_matrix_quarter_scan_driver_top.sv
// led_matrix_quarter_scan_driver_top: top level of the quarter-scan led panel driver
// depends on: lmqs_pkg, lmqs_front, lmqs_back, lmqs_out_q
//
// usage:
//   input queue (push/full): req_type 0 is a pixel write (pixel_x, pixel_y, pixel_on),
//   req_type 1 is a scan tick. up to two items queue ahead of the back end.
//   result queue (empty/pop): a tick yields 32 groups of eight inverted bank bytes;
//   the final group has last set and carries row_select. writes yield nothing.
// timing:
//   a pixel write is a read-modify-write of the frame store: read in S_IDLE, write in S_WRITE.
//   a tick starts with its first group read in S_IDLE, then S_SCAN pushes the groups while the
//   receiver keeps up; the single frame store read port sets one group per cycle.
//   first group passes the frame store read register and then the result queue on its way out.
// reset:
//   frame store reads as all zero (per-address valid bits cleared), scan row is 0,
//   both queues are empty. no clearing pass is needed.
// stall:
//   when the result queue is full the back end holds its group; the input queue
//   keeps taking items until its two entries are used, then full goes high.
module led_matrix_quarter_scan_driver_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        req_type,
    input  logic [5:0]  pixel_x,
    input  logic [6:0]  pixel_y,
    input  logic        pixel_on,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] lane_bytes,
    output logic [1:0]  row_select,
    output logic        last
);
    import lmqs_pkg::*;

    logic      op_valid;
    op_t       op;
    logic      op_pop;
    logic      res_push;
    out_item_t res_item;
    logic      res_full;
    out_item_t head_item;

    // request decode and queue
    lmqs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .req_type (req_type),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .pixel_on (pixel_on),
        .op_valid (op_valid),
        .op       (op),
        .op_pop   (op_pop)
    );

    // frame store and scan sequencer
    lmqs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op       (op),
        .op_pop   (op_pop),
        .out_push (res_push),
        .out_item (res_item),
        .out_full (res_full)
    );

    // result queue
    lmqs_out_q u_out_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_push  (res_push),
        .in_item  (res_item),
        .in_full  (res_full),
        .pop      (pop),
        .empty    (empty),
        .out_item (head_item)
    );

    // result fields
    assign lane_bytes = head_item.lanes;
    assign row_select = head_item.row_sel;
    assign last       = head_item.last;

endmodule
